/* sv/binary_to_padded_decimal_ascii_core_assert.svh */
// Assertion macros used by the top-level RTL file of the decimal text converter.
// No dependencies; the including module must have clk and rst_n.
`ifndef BINARY_TO_PADDED_DECIMAL_ASCII_CORE_ASSERT_SVH
`define BINARY_TO_PADDED_DECIMAL_ASCII_CORE_ASSERT_SVH

// Checked only outside reset.
`define BPDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define BPDA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/bpda_pkg.sv */
// Shared constants and types of the decimal text converter.
// No dependencies.
`timescale 1ns / 1ps

package bpda_pkg;

  localparam int WIDTH_BITS = 7;
  localparam int NDIG_BITS  = 5;

  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] width;
    logic [NDIG_BITS-1:0]  ndig;
  } bpda_meta_t;

  localparam int META_BITS = $bits(bpda_meta_t);

endpackage

/* sv/bpda_front.sv */
// Front end: accepts a value, converts it to BCD by shift-add-3 and counts digits.
// Depends on bpda_pkg.
`timescale 1ns / 1ps

module bpda_front import bpda_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int VALUE_BITS = 64,
  parameter int DIGITS     = 20
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [VALUE_BITS-1:0]           in_value,
  input  logic [WIDTH_BITS-1:0]           in_min_width,
  output logic                            push_valid,
  input  logic                            push_ready,
  output logic [META_BITS+DIGITS*4-1:0]   push_data
);

  localparam int DW    = DIGITS * 4;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_HOLD
  } front_state_t;

  front_state_t          state_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [DW-1:0]         bcd_r;
  logic [DW-1:0]         bcd_adj;
  logic [CNT_W-1:0]      cnt_r;
  logic [WIDTH_BITS-1:0] width_r;
  logic [WIDTH_BITS-1:0] width_sat;
  bpda_meta_t            meta;

  assign width_sat = (in_min_width > WIDTH_BITS'(MAX_WIDTH)) ?
                     WIDTH_BITS'(MAX_WIDTH) : in_min_width;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                     : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    meta.width = width_r;
    meta.ndig  = NDIG_BITS'(1);
    for (int i = 1; i < DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        meta.ndig = NDIG_BITS'(i + 1);
      end
    end
  end

  assign busy       = (state_r != F_IDLE);
  assign push_valid = (state_r == F_HOLD);
  assign push_data  = {meta, bcd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (start) begin
            val_r   <= in_value;
            bcd_r   <= '0;
            cnt_r   <= CNT_W'(VALUE_BITS);
            width_r <= width_sat;
            state_r <= F_CONV;
          end
        end
        F_CONV: begin
          bcd_r <= {bcd_adj[DW-2:0], val_r[VALUE_BITS-1]};
          val_r <= {val_r[VALUE_BITS-2:0], 1'b0};
          cnt_r <= cnt_r - CNT_W'(1);
          if (cnt_r == CNT_W'(1)) begin
            state_r <= F_HOLD;
          end
        end
        F_HOLD: begin
          if (push_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

/* sv/bpda_queue.sv */
// Two-entry queue that decouples the converter from the character emitter.
// No dependencies.
`timescale 1ns / 1ps

module bpda_queue #(
  parameter int EW = 92
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  logic [EW-1:0] push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output logic [EW-1:0] pop_data
);

  logic [1:0][EW-1:0] entry_r;
  logic               wr_ptr_r;
  logic               rd_ptr_r;
  logic [1:0]         count_r;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

/* sv/bpda_back.sv */
// Back end: emits pad spaces and then digits, one character per beat.
// Depends on bpda_pkg.
`timescale 1ns / 1ps

module bpda_back import bpda_pkg::*; #(
  parameter int DIGITS = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  logic [META_BITS+DIGITS*4-1:0] pop_data,
  output logic                          out_valid,
  output logic [7:0]                    out_char,
  output logic                          out_last
);

  localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  typedef enum logic {
    B_IDLE,
    B_EMIT
  } back_state_t;

  back_state_t                state_r;
  logic [DIGITS-1:0][3:0]     dig_r;
  logic [NDIG_BITS-1:0]       ndig_r;
  logic [WIDTH_BITS-1:0]      rem_r;
  logic [WIDTH_BITS-1:0]      rem_m1;
  logic [WIDTH_BITS-1:0]      total;
  logic [WIDTH_BITS-1:0]      ndig_ext;
  logic [7:0]                 char_nxt;
  logic                       out_valid_r;
  logic [7:0]                 out_char_r;
  logic                       out_last_r;
  bpda_meta_t                 meta;

  assign meta     = pop_data[META_BITS+DIGITS*4-1 -: META_BITS];
  assign ndig_ext = {{(WIDTH_BITS-NDIG_BITS){1'b0}}, meta.ndig};
  assign total    = (meta.width > ndig_ext) ? meta.width : ndig_ext;
  assign rem_m1   = rem_r - WIDTH_BITS'(1);

  always_comb begin
    if (rem_r > {{(WIDTH_BITS-NDIG_BITS){1'b0}}, ndig_r}) begin
      char_nxt = CHAR_SPACE;
    end else begin
      char_nxt = CHAR_ZERO + {4'd0, dig_r[rem_m1[IDX_W-1:0]]};
    end
  end

  assign pop_ready = (state_r == B_IDLE);
  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (pop_valid) begin
            dig_r   <= pop_data[DIGITS*4-1:0];
            ndig_r  <= meta.ndig;
            rem_r   <= total;
            state_r <= B_EMIT;
          end
        end
        B_EMIT: begin
          out_valid_r <= 1'b1;
          out_char_r  <= char_nxt;
          out_last_r  <= (rem_r == WIDTH_BITS'(1));
          rem_r       <= rem_m1;
          if (rem_r == WIDTH_BITS'(1)) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

/* sv/binary_to_padded_decimal_ascii_core.sv */
// Top level of the binary to padded decimal text converter.
// Depends on bpda_pkg, bpda_front, bpda_queue, bpda_back and the assertion header.
//
// Usage: drive in_value and in_min_width with start high; the item is taken at
// the edge where start is high and busy is low. busy stays high while the
// converter runs: shift-add-3 over all VALUE_BITS bits, then the hand-off of the
// BCD digits to a two-entry queue, which waits while the queue is full.
// The emitter pulls one entry and sends one character per beat on out_char,
// with out_valid high for exactly one cycle per beat and out_last high on the
// final character. A value's text is max(width, digit count) beats long, up to
// MAX_WIDTH; the emitter returns to idle and loads the next entry between texts.
// The first character follows the conversion, the queue and the emitter's load
// when the emitter is free. The converter can take a new value once its digits
// are queued, while the emitter still sends older text; the slower half sets the rate.
// The receiver cannot stall; the emitter never waits on it. Synchronous reset
// empties the queue and returns both halves to idle; no result is pending after it.
`timescale 1ns / 1ps

module binary_to_padded_decimal_ascii_core import bpda_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic [WIDTH_BITS-1:0] in_min_width,
  output logic                  out_valid,
  output logic [7:0]            out_char,
  output logic                  out_last
);

`include "binary_to_padded_decimal_ascii_core_assert.svh"

  localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int EW     = META_BITS + DIGITS * 4;

  logic          push_valid;
  logic          push_ready;
  logic [EW-1:0] push_data;
  logic          pop_valid;
  logic          pop_ready;
  logic [EW-1:0] pop_data;
  logic          char_ok;

  bpda_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .VALUE_BITS (VALUE_BITS),
    .DIGITS     (DIGITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .in_min_width (in_min_width),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  bpda_queue #(
    .EW (EW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  bpda_back #(
    .DIGITS (DIGITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_char  (out_char),
    .out_last  (out_last)
  );

  assign char_ok = (out_char == CHAR_SPACE) ||
                   ((out_char >= CHAR_ZERO) && (out_char <= CHAR_NINE));

  `BPDA_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && !busy, "beat or busy after reset")
  `BPDA_ASSERT(a_accept_busy, start && !busy |=> busy, "converter idle after accepting an item")
  `BPDA_ASSERT(a_char_legal, out_valid |-> char_ok, "illegal character")
  `BPDA_ASSERT(a_no_space_last, out_valid && out_last |-> out_char != CHAR_SPACE, "last is space")

endmodule

/* dv/binary_to_padded_decimal_ascii_core_tb.sv */
// Self-checking testbench for binary_to_padded_decimal_ascii_core: drives values and widths,
// predicts the padded decimal text of each accepted value and checks every character beat.
// Depends on bpda_pkg and the RTL of the converter.
`timescale 1ns / 1ps

module binary_to_padded_decimal_ascii_core_tb;
  import bpda_pkg::*;

  localparam int MAX_WIDTH  = 64;
  localparam int VALUE_BITS = 64;
  localparam int STALL_LIMIT = 1000;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [VALUE_BITS-1:0] in_value;
  logic [WIDTH_BITS-1:0] in_min_width;
  logic                  out_valid;
  logic [7:0]            out_char;
  logic                  out_last;

  text_char_t expected_text[$];
  int         error_count;
  int         stall_cycles;
  bit         gaps_on;

  binary_to_padded_decimal_ascii_core #(
    .MAX_WIDTH (MAX_WIDTH),
    .VALUE_BITS(VALUE_BITS)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_value    (in_value),
    .in_min_width(in_min_width),
    .out_valid   (out_valid),
    .out_char    (out_char),
    .out_last    (out_last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic void predict_decimal_text(input logic [VALUE_BITS-1:0] value,
                                               input logic [WIDTH_BITS-1:0] min_width);
    logic [7:0]            digits[20];
    logic [VALUE_BITS-1:0] rem;
    text_char_t            tc;
    int                    ndig;
    int                    eff_width;
    int                    total;
    int                    pad;
    rem  = value;
    ndig = 0;
    do begin
      digits[ndig] = CHAR_ZERO + 8'(rem % 10);
      ndig++;
      rem = rem / 10;
    end while (rem != 0);
    eff_width = (int'(min_width) > MAX_WIDTH) ? MAX_WIDTH : int'(min_width);
    total = (eff_width > ndig) ? eff_width : ndig;
    pad   = total - ndig;
    for (int k = 0; k < total; k++) begin
      tc.ch   = (k < pad) ? CHAR_SPACE : digits[ndig - 1 - (k - pad)];
      tc.last = (k == total - 1);
      expected_text.push_back(tc);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      predict_decimal_text(in_value, in_min_width);
    end
  end

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_valid) begin
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("character 0x%02h with no value pending", out_char));
      end else begin
        want = expected_text.pop_front();
        if (out_char !== want.ch) begin
          report_mismatch($sformatf("char 0x%02h, wanted 0x%02h", out_char, want.ch));
        end
        if (out_last !== want.last) begin
          report_mismatch($sformatf("last %b, wanted %b", out_last, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    if (out_valid || (start && !busy)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_value(input logic [VALUE_BITS-1:0] value,
                            input logic [WIDTH_BITS-1:0] min_width);
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    start        <= 1'b1;
    in_value     <= value;
    in_min_width <= min_width;
    do begin
      @(posedge clk);
    end while (busy);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_text.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic test_zero_value();
    send_value('0, 7'd0);
    send_value('0, 7'd1);
    send_value('0, 7'd2);
    send_value('0, 7'd64);
    send_value('0, 7'd127);
    wait_drained();
  endtask

  task automatic test_width_cap();
    send_value('1, 7'd64);
    send_value('1, 7'd65);
    send_value('1, 7'd127);
    send_value(64'd1, 7'd85);
    send_value(64'h5555_5555_5555_5555, 7'd100);
    wait_drained();
  endtask

  task automatic test_padding_edges();
    send_value('1, 7'd0);
    send_value('1, 7'd20);
    send_value('1, 7'd21);
    send_value(64'd9, 7'd1);
    send_value(64'd10, 7'd2);
    send_value(64'd99, 7'd3);
    send_value(64'd12345, 7'd4);
    send_value(64'd12345, 7'd5);
    send_value(64'd12345, 7'd6);
    send_value(64'd10000000000000000000, 7'd0);
    send_value(64'd9999999999999999999, 7'd19);
    send_value(64'hAAAA_AAAA_AAAA_AAAA, 7'd42);
    wait_drained();
  endtask

  task automatic send_random_items(input int count);
    logic [VALUE_BITS-1:0] value;
    logic [WIDTH_BITS-1:0] min_width;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0:       value = '0;
        1:       value = '1;
        default: value = {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: min_width = 7'($urandom_range(0, 24));
        6, 7:             min_width = 7'($urandom_range(0, 64));
        8:                min_width = 7'($urandom_range(65, 127));
        default:          min_width = 7'($urandom_range(15, 21));
      endcase
      send_value(value, min_width);
    end
  endtask

  task automatic test_random_gapped();
    gaps_on = 1'b1;
    send_random_items(100);
    wait_drained();
    send_random_items(100);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    gaps_on = 1'b0;
    send_random_items(40);
    wait_drained();
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_value     = '0;
    in_min_width = '0;
    error_count  = 0;
    stall_cycles = 0;
    gaps_on      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_zero_value();
    test_width_cap();
    test_padding_edges();
    test_random_gapped();
    test_back_to_back();

    repeat (VALUE_BITS + 8) @(posedge clk);
    if (expected_text.size() != 0) begin
      report_mismatch($sformatf("%0d characters never arrived", expected_text.size()));
    end
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* binary_to_padded_decimal_ascii_core.f */
+incdir+sv
sv/bpda_pkg.sv
sv/bpda_front.sv
sv/bpda_queue.sv
sv/bpda_back.sv
sv/binary_to_padded_decimal_ascii_core.sv
dv/binary_to_padded_decimal_ascii_core_tb.sv
